[rtl/rgbycc_pkg.sv]
package rgbycc_pkg;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb8_type;

   // luma weights
   localparam logic [15:0] Y_R = 16'd19595;
   localparam logic [15:0] Y_G = 16'd38469;
   localparam logic [15:0] Y_B = 16'd7471;

   // chroma weight magnitudes, signs applied in the sum
   localparam logic [15:0] CB_R = 16'd11075;
   localparam logic [15:0] CB_G = 16'd21692;
   localparam logic [15:0] CR_G = 16'd27459;
   localparam logic [15:0] CR_B = 16'd5308;
   localparam int          HALF_SHIFT = 15;

   localparam logic [8:0]  LUMA_OFFSET   = 9'd16;
   localparam logic [8:0]  LUMA_MAX      = 9'd235;
   localparam logic [7:0]  CHROMA_OFFSET = 8'd128;
   localparam logic [7:0]  CHROMA_MIN    = 8'd16;
   localparam logic [7:0]  CHROMA_MAX    = 8'd240;

   localparam logic [31:0] BLACK_PAIR_WORD = 32'h0080_0080;

   // rgb565 to 8 bits per channel by replicating the top bits
   function automatic rgb8_type widen565(input logic [15:0] px);
      rgb8_type c;
      c.r = {px[15:11], px[15:13]};
      c.g = {px[10:5], px[10:9]};
      c.b = {px[4:0], px[4:2]};
      return c;
   endfunction

endpackage

[rtl/rgbycc_luma.sv]
module rgbycc_luma (
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] pixel,
   output logic [7:0]  luma
);

   rgbycc_pkg::rgb8_type c;
   logic [23:0] pr_in, pg_in, pb_in;
   logic [23:0] pr_ff, pg_ff, pb_ff;
   logic [23:0] sum;
   logic [8:0]  y_raw;

   assign c     = rgbycc_pkg::widen565(pixel);
   assign pr_in = 24'(c.r) * 24'(rgbycc_pkg::Y_R);
   assign pg_in = 24'(c.g) * 24'(rgbycc_pkg::Y_G);
   assign pb_in = 24'(c.b) * 24'(rgbycc_pkg::Y_B);

   always_ff @(posedge clock) begin
      if (load) begin
         pr_ff <= pr_in;
         pg_ff <= pg_in;
         pb_ff <= pb_in;
      end
   end

   // sum stays below 2^24, lower bound of 16 holds by construction
   assign sum   = pr_ff + pg_ff + pb_ff;
   assign y_raw = {1'b0, sum[23:16]} + rgbycc_pkg::LUMA_OFFSET;
   assign luma  = (y_raw > rgbycc_pkg::LUMA_MAX) ? rgbycc_pkg::LUMA_MAX[7:0] : y_raw[7:0];

endmodule

[rtl/rgbycc_chroma.sv]
module rgbycc_chroma (
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] first_pixel,
   input  logic [15:0] second_pixel,
   output logic [7:0]  cb,
   output logic [7:0]  cr
);

   rgbycc_pkg::rgb8_type c1, c2;
   logic [8:0]  sum_r, sum_g, sum_b;
   logic [7:0]  avg_r, avg_g, avg_b;
   logic [23:0] cb_r_in, cb_g_in, cb_b_in, cr_r_in, cr_g_in, cr_b_in;
   logic [23:0] cb_r_ff, cb_g_ff, cb_b_ff, cr_r_ff, cr_g_ff, cr_b_ff;
   logic [24:0] cb_sum, cr_sum;
   logic [7:0]  cb_raw, cr_raw;

   assign c1    = rgbycc_pkg::widen565(first_pixel);
   assign c2    = rgbycc_pkg::widen565(second_pixel);
   assign sum_r = {1'b0, c1.r} + {1'b0, c2.r};
   assign sum_g = {1'b0, c1.g} + {1'b0, c2.g};
   assign sum_b = {1'b0, c1.b} + {1'b0, c2.b};
   assign avg_r = sum_r[8:1];
   assign avg_g = sum_g[8:1];
   assign avg_b = sum_b[8:1];

   assign cb_r_in = 24'(avg_r) * 24'(rgbycc_pkg::CB_R);
   assign cb_g_in = 24'(avg_g) * 24'(rgbycc_pkg::CB_G);
   assign cb_b_in = 24'(avg_b) << rgbycc_pkg::HALF_SHIFT;
   assign cr_r_in = 24'(avg_r) << rgbycc_pkg::HALF_SHIFT;
   assign cr_g_in = 24'(avg_g) * 24'(rgbycc_pkg::CR_G);
   assign cr_b_in = 24'(avg_b) * 24'(rgbycc_pkg::CR_B);

   always_ff @(posedge clock) begin
      if (load) begin
         cb_r_ff <= cb_r_in;
         cb_g_ff <= cb_g_in;
         cb_b_ff <= cb_b_in;
         cr_r_ff <= cr_r_in;
         cr_g_ff <= cr_g_in;
         cr_b_ff <= cr_b_in;
      end
   end

   // two's complement sums, bits 23:16 give the floored quotient in -128..127
   assign cb_sum = {1'b0, cb_b_ff} - {1'b0, cb_r_ff} - {1'b0, cb_g_ff};
   assign cr_sum = {1'b0, cr_r_ff} - {1'b0, cr_g_ff} - {1'b0, cr_b_ff};
   assign cb_raw = cb_sum[23:16] + rgbycc_pkg::CHROMA_OFFSET;
   assign cr_raw = cr_sum[23:16] + rgbycc_pkg::CHROMA_OFFSET;

   always_comb begin
      if (cb_raw < rgbycc_pkg::CHROMA_MIN) begin
         cb = rgbycc_pkg::CHROMA_MIN;
      end else if (cb_raw > rgbycc_pkg::CHROMA_MAX) begin
         cb = rgbycc_pkg::CHROMA_MAX;
      end else begin
         cb = cb_raw;
      end
      if (cr_raw < rgbycc_pkg::CHROMA_MIN) begin
         cr = rgbycc_pkg::CHROMA_MIN;
      end else if (cr_raw > rgbycc_pkg::CHROMA_MAX) begin
         cr = rgbycc_pkg::CHROMA_MAX;
      end else begin
         cr = cr_raw;
      end
   end

endmodule

[rtl/rgb565_pair_to_ycbycr.sv]
// channel   | direction | ports
// ----------+-----------+---------------------------------------------
// request   | in        | req_valid, req_stall, req_first_pixel, req_second_pixel
// response  | out       | rsp_valid, rsp_stall, rsp_ycbycr_word
//
// two pipeline stages: products, then sum, clamp and pack; one item per cycle unless rsp_stall holds the output
// rsp_valid rises when the accepted item moves from the product stage into the output register
// reset clears the stage valid flags only
// a stalled response holds the output register; the product stage keeps
// accepting until it is full, so req_stall follows rsp_stall combinationally
module rgb565_pair_to_ycbycr (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_first_pixel,
   input  logic [15:0] req_second_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_ycbycr_word
);

   logic        s1_load, s2_load;
   logic        s1_valid_ff, s1_valid_in;
   logic        zero_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] word_ff, word_in;
   logic [7:0]  y1, y2, cb, cr;

   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   rgbycc_luma u_luma_first (
      .clock (clock),
      .load  (s1_load),
      .pixel (req_first_pixel),
      .luma  (y1)
   );

   rgbycc_luma u_luma_second (
      .clock (clock),
      .load  (s1_load),
      .pixel (req_second_pixel),
      .luma  (y2)
   );

   rgbycc_chroma u_chroma (
      .clock        (clock),
      .load         (s1_load),
      .first_pixel  (req_first_pixel),
      .second_pixel (req_second_pixel),
      .cb           (cb),
      .cr           (cr)
   );

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;
   // black pair bypasses the conversion
   assign word_in      = zero_ff ? rgbycc_pkg::BLACK_PAIR_WORD : {y1, cb, y2, cr};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         zero_ff <= ((req_first_pixel | req_second_pixel) == 16'd0);
      end
      if (s2_load && s1_valid_ff) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ycbycr_word = word_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty product stage");

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted item lost in product stage");

   a_s1_moves_on : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> rsp_valid_ff)
      else $error("item lost between stages");

   a_luma_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (word_ff != rgbycc_pkg::BLACK_PAIR_WORD)) |->
      (word_ff[31:24] >= 8'd16 && word_ff[31:24] <= 8'd235 &&
       word_ff[15:8] >= 8'd16 && word_ff[15:8] <= 8'd235))
      else $error("luma out of range");

   a_chroma_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
      (word_ff[23:16] >= 8'd16 && word_ff[23:16] <= 8'd240 &&
       word_ff[7:0] >= 8'd16 && word_ff[7:0] <= 8'd240))
      else $error("chroma out of range");

endmodule
